FILE: sv/tasc_pkg.sv
package tasc_pkg;

    localparam int DIV_BITS  = 32;
    localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    typedef enum logic [1:0] {
        CMD_CAPTURE  = 2'd0,
        CMD_OVERFLOW = 2'd1,
        CMD_POT      = 2'd2,
        CMD_REQUEST  = 2'd3
    } tasc_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPN     = 3'd0,
        REG_NUM      = 3'd1,
        REG_SMIN     = 3'd2,
        REG_SMAX     = 3'd3,
        REG_FF       = 3'd4,
        REG_PG       = 3'd5,
        REG_DB       = 3'd6,
        REG_RESERVED = 3'd7
    } tasc_reg_t;

    localparam logic [5:0]  CAPN_RST = 6'd20;
    localparam logic [23:0] NUM_RST  = 24'd833333;
    localparam logic [7:0]  SMIN_RST = 8'd20;
    localparam logic [7:0]  SMAX_RST = 8'd90;
    localparam logic [9:0]  FF_RST   = 10'd755;
    localparam logic [9:0]  PG_RST   = 10'd184;
    localparam logic [6:0]  DB_RST   = 7'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_AVG,
        ST_DIV_RPM,
        ST_MUL,
        ST_SUM,
        ST_FINISH
    } tasc_state_t;

    typedef struct packed {
        logic load;
        logic avg_start;
        logic rpm_start;
        logic rpm_zero;
        logic rpm_store;
        logic mul;
        logic sum;
        logic out_load;
    } tasc_cmd_bus_t;

    typedef struct packed {
        logic avg_pending;
        logic active;
        logic div_done;
        logic avg_zero;
    } tasc_status_t;

endpackage

FILE: sv/tasc_div.sv
module tasc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tasc_pkg::DIV_BITS-1:0] dividend,
    input  logic [tasc_pkg::DIV_BITS-1:0] divisor,
    output logic                         busy,
    output logic                         done,
    output logic [tasc_pkg::DIV_BITS-1:0] quotient
);

    localparam int W  = tasc_pkg::DIV_BITS;
    localparam int CW = tasc_pkg::DIV_CNT_W;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W:0]    rem_shift;
    logic          fits;

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(W);
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
            if (fits)
            begin
                rem_next = W'(rem_shift - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = rem_shift[W-1:0];
            end
            quo_next = {quo_reg[W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("divider done while still iterating");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && cnt_reg == CW'(1) && !start) |=> done)
        else $error("divider missed done");

endmodule

FILE: sv/tasc_datapath.sv
module tasc_datapath #(
    parameter int MAX_CAPTURES  = 32,
    parameter int EXT_TICK_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tasc_pkg::tasc_cmd_bus_t        ctl,
    output tasc_pkg::tasc_status_t         status,
    input  logic                           cfg_we,
    input  logic [tasc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tasc_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic [1:0]                     cmd,
    input  logic [15:0]                    capture_ticks,
    input  logic [9:0]                     pot_sample,
    input  logic [7:0]                     speed_request,
    output logic [7:0]                     pwm_duty,
    output logic [15:0]                    measured_rpm,
    output logic                           rpm_updated,
    output logic                           control_on
);

    localparam int W = tasc_pkg::DIV_BITS;
    localparam logic [6:0]  CAP_LIM  = 7'(MAX_CAPTURES);
    localparam logic [31:0] EXT_MASK = 32'((64'd1 << EXT_TICK_BITS) - 64'd1);

    // configuration
    logic [5:0]  capn_reg;
    logic [23:0] num_reg;
    logic [7:0]  smin_reg, smax_reg;
    logic [9:0]  ff_reg, pg_reg;
    logic [6:0]  db_reg;

    // block state
    logic [7:0]  ovf_reg, ovf_next;
    logic [5:0]  seen_reg, seen_next;
    logic [31:0] sum_reg, sum_next;
    logic [15:0] rpm_reg, rpm_next;
    logic [7:0]  target_reg, target_next;
    logic        active_reg, active_next;
    logic [7:0]  duty_reg, duty_next;
    logic        pend_reg, pend_next;
    logic        upd_reg, upd_next;

    logic [17:0]        ffp_reg;
    logic signed [18:0] pgp_reg;

    logic [6:0]  n_eff;
    logic [5:0]  seen_inc;
    logic [31:0] ext_ticks;

    logic signed [17:0] err_raw;
    logic signed [7:0]  err_sat;
    logic [7:0]         err_mag;
    logic [17:0]        ffp_next;
    logic signed [18:0] pgp_next;
    logic signed [19:0] ctl_sum;
    logic [11:0]        ctl_shift;
    logic [7:0]         ctl_duty;

    logic         div_start, div_busy, div_done;
    logic [W-1:0] div_dividend, div_divisor, div_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capn_reg <= tasc_pkg::CAPN_RST;
            num_reg  <= tasc_pkg::NUM_RST;
            smin_reg <= tasc_pkg::SMIN_RST;
            smax_reg <= tasc_pkg::SMAX_RST;
            ff_reg   <= tasc_pkg::FF_RST;
            pg_reg   <= tasc_pkg::PG_RST;
            db_reg   <= tasc_pkg::DB_RST;
        end
        else if (cfg_we)
        begin
            unique case (tasc_pkg::tasc_reg_t'(cfg_index))
                tasc_pkg::REG_CAPN: capn_reg <= cfg_data[5:0];
                tasc_pkg::REG_NUM:  num_reg  <= cfg_data[23:0];
                tasc_pkg::REG_SMIN: smin_reg <= cfg_data[7:0];
                tasc_pkg::REG_SMAX: smax_reg <= cfg_data[7:0];
                tasc_pkg::REG_FF:   ff_reg   <= cfg_data[9:0];
                tasc_pkg::REG_PG:   pg_reg   <= cfg_data[9:0];
                tasc_pkg::REG_DB:   db_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign n_eff = (capn_reg == '0) ? 7'd1 :
                   ({1'b0, capn_reg} > CAP_LIM) ? CAP_LIM : {1'b0, capn_reg};
    assign seen_inc  = seen_reg + 6'd1;
    assign ext_ticks = {8'd0, ovf_reg, capture_ticks} & EXT_MASK;

    // control law operands
    always_comb
    begin
        err_raw = $signed({10'd0, target_reg}) - $signed({2'd0, rpm_reg});
        if (err_raw > 18'sd127)
        begin
            err_sat = 8'sd127;
        end
        else if (err_raw < -18'sd128)
        begin
            err_sat = -8'sd128;
        end
        else
        begin
            err_sat = err_raw[7:0];
        end
        err_mag  = err_sat[7] ? 8'(-{1'b1, err_sat}) : err_sat;
        ffp_next = ff_reg * target_reg;
        if (err_mag > {1'b0, db_reg})
        begin
            pgp_next = $signed({1'b0, pg_reg}) * err_sat;
        end
        else
        begin
            pgp_next = '0;
        end
        ctl_sum   = $signed({2'b00, ffp_reg}) + 20'(pgp_reg);
        ctl_shift = ctl_sum[19:8];
        if (ctl_sum[19])
        begin
            ctl_duty = '0;
        end
        else if (ctl_shift > 12'd255)
        begin
            ctl_duty = 8'hFF;
        end
        else
        begin
            ctl_duty = ctl_shift[7:0];
        end
    end

    assign div_start    = ctl.avg_start | ctl.rpm_start;
    assign div_dividend = ctl.avg_start ? sum_reg : {8'd0, num_reg};
    assign div_divisor  = ctl.avg_start ? {25'd0, n_eff} : div_q;

    tasc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        ovf_next    = ovf_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        rpm_next    = rpm_reg;
        target_next = target_reg;
        active_next = active_reg;
        duty_next   = duty_reg;
        pend_next   = pend_reg;
        upd_next    = upd_reg;
        if (ctl.load)
        begin
            upd_next = 1'b0;
            case (tasc_pkg::tasc_cmd_t'(cmd))
                tasc_pkg::CMD_CAPTURE:
                begin
                    sum_next  = sum_reg + ext_ticks;
                    seen_next = seen_inc;
                    pend_next = ({1'b0, seen_inc} >= n_eff);
                    ovf_next  = '0;
                end
                tasc_pkg::CMD_OVERFLOW:
                begin
                    ovf_next = ovf_reg + 8'd1;
                end
                tasc_pkg::CMD_POT:
                begin
                    if (target_reg == '0)
                    begin
                        duty_next = pot_sample[9:2];
                    end
                end
                default:
                begin
                    if (speed_request >= smin_reg && speed_request <= smax_reg)
                    begin
                        target_next = speed_request;
                        active_next = 1'b1;
                    end
                    else
                    begin
                        active_next = 1'b0;
                        duty_next   = '0;
                    end
                end
            endcase
        end
        if (ctl.avg_start)
        begin
            sum_next  = '0;
            seen_next = '0;
            pend_next = 1'b0;
        end
        if (ctl.rpm_zero)
        begin
            rpm_next = 16'hFFFF;
            upd_next = 1'b1;
        end
        if (ctl.rpm_store)
        begin
            rpm_next = (div_q > 32'h0000FFFF) ? 16'hFFFF : div_q[15:0];
            upd_next = 1'b1;
        end
        if (ctl.sum)
        begin
            duty_next = ctl_duty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg    <= '0;
            seen_reg   <= '0;
            sum_reg    <= '0;
            rpm_reg    <= '0;
            target_reg <= '0;
            active_reg <= 1'b0;
            duty_reg   <= '0;
            pend_reg   <= 1'b0;
            upd_reg    <= 1'b0;
        end
        else
        begin
            ovf_reg    <= ovf_next;
            seen_reg   <= seen_next;
            sum_reg    <= sum_next;
            rpm_reg    <= rpm_next;
            target_reg <= target_next;
            active_reg <= active_next;
            duty_reg   <= duty_next;
            pend_reg   <= pend_next;
            upd_reg    <= upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            ffp_reg <= ffp_next;
            pgp_reg <= pgp_next;
        end
        if (ctl.out_load)
        begin
            pwm_duty     <= duty_reg;
            measured_rpm <= rpm_reg;
            rpm_updated  <= upd_reg;
            control_on   <= active_reg;
        end
    end

    assign status.avg_pending = pend_reg;
    assign status.active      = active_reg;
    assign status.div_done    = div_done;
    assign status.avg_zero    = (div_q == '0);

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted mid-operation");

    a_avg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.avg_start |=> (sum_reg == '0 && seen_reg == '0 && !pend_reg))
        else $error("average start did not clear accumulator");

    a_rpm_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rpm_store || ctl.rpm_zero) |=> upd_reg)
        else $error("rpm update not flagged");

endmodule

FILE: sv/tasc_ctrl.sv
module tasc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  tasc_pkg::tasc_status_t  status,
    output tasc_pkg::tasc_cmd_bus_t ctl
);

    tasc_pkg::tasc_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tasc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tasc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = tasc_pkg::ST_CHECK;
                end
            end
            tasc_pkg::ST_CHECK:
            begin
                if (status.avg_pending)
                begin
                    ctl.avg_start = 1'b1;
                    state_next    = tasc_pkg::ST_DIV_AVG;
                end
                else if (status.active)
                begin
                    state_next = tasc_pkg::ST_MUL;
                end
                else
                begin
                    state_next = tasc_pkg::ST_FINISH;
                end
            end
            tasc_pkg::ST_DIV_AVG:
            begin
                if (status.div_done)
                begin
                    if (status.avg_zero)
                    begin
                        ctl.rpm_zero = 1'b1;
                        state_next   = status.active ? tasc_pkg::ST_MUL
                                                     : tasc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        ctl.rpm_start = 1'b1;
                        state_next    = tasc_pkg::ST_DIV_RPM;
                    end
                end
            end
            tasc_pkg::ST_DIV_RPM:
            begin
                if (status.div_done)
                begin
                    ctl.rpm_store = 1'b1;
                    state_next    = status.active ? tasc_pkg::ST_MUL
                                                  : tasc_pkg::ST_FINISH;
                end
            end
            tasc_pkg::ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = tasc_pkg::ST_SUM;
            end
            tasc_pkg::ST_SUM:
            begin
                ctl.sum    = 1'b1;
                state_next = tasc_pkg::ST_FINISH;
            end
            tasc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = tasc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tasc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("transaction accepted while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> out_valid)
        else $error("loaded result not presented");

endmodule

FILE: sv/tach_averaging_speed_controller.sv
// Tachometer speed controller. Each input transaction is one event (capture,
// timer overflow, pot sample or speed request) and yields exactly one result
// transaction carrying duty, rpm, an rpm-updated flag and the control state.
// Items are handled one at a time. An event that does not close an average
// passes through a check state to the result, and closed-loop control adds a
// multiply and a sum state; the capture that closes an average runs the shared
// one-bit-per-cycle 32-bit divider twice (average, then rpm), and a zero
// average skips the rpm divide. A new item is accepted while the previous
// result still waits in the output register. Configuration writes take effect
// at once and should be made only while no transaction is in flight.
module tach_averaging_speed_controller #(
    parameter int MAX_CAPTURES  = 32,
    parameter int EXT_TICK_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tasc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tasc_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     cmd,
    input  logic [15:0]                    capture_ticks,
    input  logic [9:0]                     pot_sample,
    input  logic [7:0]                     speed_request,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     pwm_duty,
    output logic [15:0]                    measured_rpm,
    output logic                           rpm_updated,
    output logic                           control_on
);

    tasc_pkg::tasc_cmd_bus_t ctl;
    tasc_pkg::tasc_status_t  status;

    tasc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctl       (ctl)
    );

    tasc_datapath #(
        .MAX_CAPTURES  (MAX_CAPTURES),
        .EXT_TICK_BITS (EXT_TICK_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .capture_ticks (capture_ticks),
        .pot_sample    (pot_sample),
        .speed_request (speed_request),
        .pwm_duty      (pwm_duty),
        .measured_rpm  (measured_rpm),
        .rpm_updated   (rpm_updated),
        .control_on    (control_on)
    );

endmodule
